@@ design/pfe_pkg.sv @@
`default_nettype none

package pfe_pkg;

    localparam int unsigned ALPHA    = 26;
    localparam int unsigned CELLS    = 25;
    localparam int unsigned SIDE     = 5;
    localparam int unsigned LOWER_A  = 97;
    localparam int unsigned CASE_GAP = 32;

    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_X = 5'd23;
    localparam logic [4:0] IDX_Z = 5'd25;
    localparam logic [4:0] IDX_LAST = 5'(ALPHA - 1);
    localparam logic [4:0] CELL_COUNT = 5'(CELLS);
    localparam logic [2:0] SIDE_LAST = 3'(SIDE - 1);

    localparam logic [7:0] CH_LOWER_A = 8'(LOWER_A);
    localparam logic [7:0] CH_LOWER_END = 8'(LOWER_A + ALPHA);
    localparam logic [6:0] CH_UPPER_A = 7'(LOWER_A - CASE_GAP);

    typedef enum logic [1:0] {
        ACT_KEY  = 2'd0,
        ACT_DONE = 2'd1,
        ACT_TEXT = 2'd2,
        ACT_END  = 2'd3
    } t_action;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_rc;

    // row * 5 + col
    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        cell_of = 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    // cell -> row/col, cell below 25
    function automatic t_rc split_cell(input logic [4:0] p);
        t_rc rc;
        logic [4:0] base;
        if (p >= 5'd20)      rc.row = 3'd4;
        else if (p >= 5'd15) rc.row = 3'd3;
        else if (p >= 5'd10) rc.row = 3'd2;
        else if (p >= 5'd5)  rc.row = 3'd1;
        else                 rc.row = 3'd0;
        base   = cell_of(rc.row, 3'd0);
        rc.col = 3'(p - base);
        split_cell = rc;
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] x);
        wrap_inc = (x == SIDE_LAST) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [6:0] to_upper(input logic [4:0] idx);
        to_upper = 7'({2'b00, idx}) + CH_UPPER_A;
    endfunction

endpackage

`default_nettype wire

@@ design/pfe_if.sv @@
`default_nettype none

interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] letter;

    modport source (output valid, action, letter, input ready);
    modport sink   (input valid, action, letter, output ready);
endinterface

interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_letter;
    logic       second_of_pair;
    logic       message_end;

    modport source (output valid, cipher_letter, second_of_pair, message_end, input ready);
    modport sink   (input valid, cipher_letter, second_of_pair, message_end, output ready);
endinterface

`default_nettype wire

@@ design/playfair_digraph_encryptor_top.sv @@
`default_nettype none

// Playfair encryptor with a 5x5 square (i and j share a cell). Items carry an
// action and an ASCII character. Key letters (action 0) are placed one per
// item in arrival order, first occurrence only, j never placed. Key done
// (action 1) walks the alphabet through the same placement logic, one letter
// per cycle; later key letters and key-done items are ignored until reset.
// Text letters (action 2) are paired: a doubled letter becomes (letter, x)
// and the repeat starts the next pair; end of message (action 3) pads a held
// letter with z. Anything outside a-z is dropped, as is text before the
// square is complete. A pair gives two items out, first letter then second
// (second_of_pair set); message_end marks the second letter of a pair closed
// by end of message. For a pair, the position table and the square are
// single-port memories read one address per cycle (two positions, then two
// cells), with the rule state between them, and then the two results leave
// one per cycle from the output register while the receiver is ready. The
// input is not ready until the pair has fully left. No clearing pass is
// needed after reset.
module playfair_digraph_encryptor_top
    import pfe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfe_in_if.sink     i_in,
    pfe_out_if.source  o_out
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FILL  = 9'b000000010,
        ST_POS_A = 9'b000000100,
        ST_POS_B = 9'b000001000,
        ST_CELL  = 9'b000010000,
        ST_SQ_A  = 9'b000100000,
        ST_SQ_B  = 9'b001000000,
        ST_OUT_A = 9'b010000000,
        ST_OUT_B = 9'b100000000
    } t_state;

    // control
    t_state      r_state, n_state;
    logic        r_key_ready, n_key_ready;
    logic [4:0]  r_fill, n_fill;         // cells placed so far
    logic [4:0]  r_k, n_k;               // alphabet walk on key done
    logic [25:0] r_used, n_used;
    logic [4:0]  r_held, n_held;
    logic        r_held_vld, n_held_vld;

    // pair datapath
    logic [4:0]  r_a, r_b;               // letter indexes after j -> i
    logic        r_end;
    logic [4:0]  r_pos_q;                // position table read data
    logic [4:0]  r_pa;
    logic [4:0]  r_oa, r_ob;
    logic [4:0]  r_sq_q;                 // square read data
    logic [6:0]  r_out_letter;
    logic        r_out_second;
    logic        r_out_end;

    // memories
    logic [4:0]  r_square_mem [CELLS];
    logic [4:0]  r_pos_mem [ALPHA];

    logic        in_acc;
    logic        out_acc;
    logic        is_lower;
    logic [4:0]  in_idx;
    t_action     act;
    logic        place_req;
    logic        place_ok;
    logic [4:0]  place_idx;
    logic        pair_go;
    logic [4:0]  pair_b_raw;
    logic [4:0]  pos_addr;
    logic [4:0]  sq_addr;
    logic [4:0]  rule_oa, rule_ob;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    assign act      = t_action'(i_in.action);
    assign is_lower = (i_in.letter >= CH_LOWER_A) && (i_in.letter < CH_LOWER_END);
    assign in_idx   = 5'(i_in.letter - CH_LOWER_A);

    // shared placement unit: key letters on accept, alphabet during the walk
    assign place_idx = (r_state == ST_FILL) ? r_k : in_idx;
    assign place_req = (r_state == ST_FILL) ||
                       (in_acc && act == ACT_KEY && !r_key_ready && is_lower);
    assign place_ok  = place_req && (place_idx != IDX_J) && !r_used[place_idx] &&
                       (r_fill < CELL_COUNT);

    // a pair starts on a second text letter or on end with a held letter
    always_comb begin
        pair_go    = 1'b0;
        pair_b_raw = IDX_Z;
        if (in_acc && r_key_ready && r_held_vld) begin
            if (act == ACT_TEXT && is_lower) begin
                pair_go    = 1'b1;
                pair_b_raw = (in_idx == r_held) ? IDX_X : in_idx;
            end else if (act == ACT_END) begin
                pair_go    = 1'b1;
                pair_b_raw = IDX_Z;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_key_ready = r_key_ready;
        n_fill      = r_fill;
        n_k         = r_k;
        n_used      = r_used;
        n_held      = r_held;
        n_held_vld  = r_held_vld;

        if (place_ok) begin
            n_used[place_idx] = 1'b1;
            n_fill            = r_fill + 5'd1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (act)
                        ACT_KEY: ;
                        ACT_DONE: begin
                            if (!r_key_ready) begin
                                n_k     = 5'd0;
                                n_state = ST_FILL;
                            end
                        end
                        ACT_TEXT: begin
                            if (r_key_ready && is_lower) begin
                                if (!r_held_vld) begin
                                    n_held     = in_idx;
                                    n_held_vld = 1'b1;
                                end else begin
                                    // a doubled letter stays held for the next pair
                                    n_held_vld = (in_idx == r_held);
                                    n_state    = ST_POS_A;
                                end
                            end
                        end
                        ACT_END: begin
                            if (r_key_ready && r_held_vld) begin
                                n_held_vld = 1'b0;
                                n_state    = ST_POS_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                n_k = r_k + 5'd1;
                if (r_k == IDX_LAST) begin
                    n_key_ready = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_POS_A: n_state = ST_POS_B;
            ST_POS_B: n_state = ST_CELL;
            ST_CELL:  n_state = ST_SQ_A;
            ST_SQ_A:  n_state = ST_SQ_B;
            ST_SQ_B:  n_state = ST_OUT_A;
            ST_OUT_A: if (out_acc) n_state = ST_OUT_B;
            ST_OUT_B: if (out_acc) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_ready <= 1'b0;
            r_fill      <= 5'd0;
            r_k         <= 5'd0;
            r_used      <= '0;
            r_held      <= 5'd0;
            r_held_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key_ready <= n_key_ready;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_used      <= n_used;
            r_held      <= n_held;
            r_held_vld  <= n_held_vld;
        end
    end

    // memory writes: one cell and one position per placement
    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_square_mem[r_fill]  <= place_idx;
            r_pos_mem[place_idx]  <= r_fill;
        end
    end

    // registered reads, one address each per cycle
    assign pos_addr = (r_state == ST_POS_A) ? r_a : r_b;
    assign sq_addr  = (r_state == ST_SQ_A) ? r_oa : r_ob;

    always_ff @(posedge i_clk) begin
        r_pos_q <= r_pos_mem[pos_addr];
        r_sq_q  <= r_square_mem[sq_addr];
    end

    pfe_rule u_rule (
        .i_pa (r_pa),
        .i_pb (r_pos_q),
        .o_oa (rule_oa),
        .o_ob (rule_ob)
    );

    always_ff @(posedge i_clk) begin
        if (pair_go) begin
            r_a   <= (r_held == IDX_J) ? IDX_I : r_held;
            r_b   <= (pair_b_raw == IDX_J) ? IDX_I : pair_b_raw;
            r_end <= (act == ACT_END);
        end
        if (r_state == ST_POS_B) begin
            r_pa <= r_pos_q;
        end
        if (r_state == ST_CELL) begin
            r_oa <= rule_oa;
            r_ob <= rule_ob;
        end
        if (r_state == ST_SQ_B) begin
            r_out_letter <= to_upper(r_sq_q);
            r_out_second <= 1'b0;
            r_out_end    <= 1'b0;
        end else if (r_state == ST_OUT_A && out_acc) begin
            r_out_letter <= to_upper(r_sq_q);
            r_out_second <= 1'b1;
            r_out_end    <= r_end;
        end
    end

    assign o_out.valid          = (r_state == ST_OUT_A) || (r_state == ST_OUT_B);
    assign o_out.cipher_letter  = r_out_letter;
    assign o_out.second_of_pair = r_out_second;
    assign o_out.message_end    = r_out_end;

    // results only come from a finished square
    a_out_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_key_ready)
        else $error("result without a complete square");

    // the walk leaves every cell filled
    a_fill_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && r_k == IDX_LAST) |=> (r_fill == CELL_COUNT))
        else $error("square not full after key done");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CELL_COUNT)
        else $error("fill count past square size");

    // no new item while a pair is still leaving
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready during output");

    // second letter follows the first without a new input
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_A && out_acc) |=> (o_out.valid && o_out.second_of_pair))
        else $error("second letter missing");

endmodule

`default_nettype wire

@@ design/pfe_rule.sv @@
`default_nettype none

// Playfair digraph rule on cell numbers: row, column or rectangle.
module pfe_rule
    import pfe_pkg::*;
(
    input  wire logic [4:0] i_pa,
    input  wire logic [4:0] i_pb,
    output logic      [4:0] o_oa,
    output logic      [4:0] o_ob
);

    t_rc a;
    t_rc b;

    always_comb begin
        a = split_cell(i_pa);
        b = split_cell(i_pb);
        // same cell falls in the row case
        if (a.row == b.row) begin
            o_oa = cell_of(a.row, wrap_inc(a.col));
            o_ob = cell_of(b.row, wrap_inc(b.col));
        end else if (a.col == b.col) begin
            o_oa = cell_of(wrap_inc(a.row), a.col);
            o_ob = cell_of(wrap_inc(b.row), b.col);
        end else begin
            o_oa = cell_of(a.row, b.col);
            o_ob = cell_of(b.row, a.col);
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_playfair_digraph_encryptor_top.sv @@
`default_nettype none

module tb_playfair_digraph_encryptor_top;
    import pfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One cipher letter as it leaves the block
    typedef struct packed {
        logic [6:0] letter;
        logic       pair_second;
        logic       msg_end;
    } t_cipher_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    pfe_in_if  in_ch();
    pfe_out_if out_ch();

    playfair_digraph_encryptor_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Shadow square: same state the block keeps, updated on every
    // accepted item so the expected cipher letters can be queued.
    // ------------------------------------------------------------------
    logic [4:0]   sq_cell [CELLS];
    logic [4:0]   sq_pos  [ALPHA];
    bit           sq_used [ALPHA];
    int unsigned  sq_fill;
    bit           sq_ready;
    logic [4:0]   held_letter;
    bit           held_valid;

    t_cipher_char cipher_expected[$];

    int errors;
    int n_items;
    int n_letters;
    int n_row;
    int n_col;
    int n_rect;
    int n_doubles;

    // Idle control shared by the sender and the receiver
    bit steady;             // no random gaps on either side while set
    int out_hold_cycles;    // long receiver hold-off, counted down below
    int out_idle;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void place_in_square(input logic [4:0] idx);
        if (idx == IDX_J || sq_used[idx] || sq_fill >= CELLS)
            return;
        sq_cell[sq_fill] = idx;
        sq_pos[idx]      = 5'(sq_fill);
        sq_used[idx]     = 1'b1;
        sq_fill++;
    endfunction

    // Encrypt one digraph and queue its two letters
    function automatic void push_digraph(input logic [4:0] a, input logic [4:0] b,
                                         input bit closing);
        int unsigned pa, pb, ra, ca, rb, cb, oa, ob;
        t_cipher_char c;
        // j shares the i cell on both sides of the pair
        if (a == IDX_J) a = IDX_I;
        if (b == IDX_J) b = IDX_I;
        pa = sq_pos[a];
        pb = sq_pos[b];
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        // same cell (xx, zz, ij) lands here too: row rule
        if (ra == rb) begin
            oa = ra * SIDE + (ca + 1) % SIDE;
            ob = rb * SIDE + (cb + 1) % SIDE;
            n_row++;
        end else if (ca == cb) begin
            oa = ((ra + 1) % SIDE) * SIDE + ca;
            ob = ((rb + 1) % SIDE) * SIDE + cb;
            n_col++;
        end else begin
            oa = ra * SIDE + cb;
            ob = rb * SIDE + ca;
            n_rect++;
        end
        c.letter      = CH_UPPER_A + 7'(sq_cell[oa]);
        c.pair_second = 1'b0;
        c.msg_end     = 1'b0;
        cipher_expected.push_back(c);
        c.letter      = CH_UPPER_A + 7'(sq_cell[ob]);
        c.pair_second = 1'b1;
        c.msg_end     = closing;
        cipher_expected.push_back(c);
    endfunction

    function automatic void encipher_item(input t_action act, input logic [7:0] ch);
        bit         lower;
        logic [4:0] idx;
        lower = (ch >= CH_LOWER_A) && (ch < CH_LOWER_END);
        idx   = lower ? 5'(ch - CH_LOWER_A) : 5'd0;
        case (act)
            ACT_KEY: begin
                if (!sq_ready && lower)
                    place_in_square(idx);
            end
            ACT_DONE: begin
                // second key done is a no-op
                if (!sq_ready) begin
                    for (int k = 0; k < ALPHA; k++)
                        place_in_square(5'(k));
                    sq_ready = 1'b1;
                end
            end
            ACT_TEXT: begin
                if (sq_ready && lower) begin
                    if (!held_valid) begin
                        held_letter = idx;
                        held_valid  = 1'b1;
                    end else if (held_letter == idx) begin
                        // doubled raw letter: pad with x, repeat stays held
                        push_digraph(held_letter, IDX_X, 1'b0);
                        n_doubles++;
                    end else begin
                        push_digraph(held_letter, idx, 1'b0);
                        held_valid = 1'b0;
                    end
                end
            end
            ACT_END: begin
                if (sq_ready && held_valid) begin
                    push_digraph(held_letter, IDX_Z, 1'b1);
                    held_valid = 1'b0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender. Entered right after a rising edge (or at the start); valid
    // only drops when a gap is taken, so back-to-back items keep it high.
    // ------------------------------------------------------------------
    task automatic send_item(input t_action act, input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.letter <= ch;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        encipher_item(act, ch);
        n_items++;
    endtask

    // Drop valid first so the last item is not taken a second time
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (cipher_expected.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] char_of(input logic [4:0] idx);
        return CH_LOWER_A + 8'(idx);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready with short and occasional long idles, plus
    // a counted hold-off that a test can request.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                out_hold_cycles--;
            end else if (out_idle > 0) begin
                out_ch.ready <= 1'b0;
                out_idle--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    out_idle = pick_gap();
            end
        end
    end

    // Checker: every accepted cipher letter against the oldest expectation
    always @(posedge i_clk) begin
        t_cipher_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_letters++;
            if (cipher_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected cipher letter %c second=%0d end=%0d", $realtime,
                         out_ch.cipher_letter, out_ch.second_of_pair, out_ch.message_end);
            end else begin
                want = cipher_expected.pop_front();
                if (out_ch.cipher_letter !== want.letter) begin
                    errors++;
                    $display("%0t: cipher_letter expected %h actual %h", $realtime,
                             want.letter, out_ch.cipher_letter);
                end
                if (out_ch.second_of_pair !== want.pair_second) begin
                    errors++;
                    $display("%0t: second_of_pair expected %0d actual %0d", $realtime,
                             want.pair_second, out_ch.second_of_pair);
                end
                if (out_ch.message_end !== want.msg_end) begin
                    errors++;
                    $display("%0t: message_end expected %0d actual %0d", $realtime,
                             want.msg_end, out_ch.message_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Text and end of message before the square exists give nothing
    task automatic test_text_before_key();
        send_item(ACT_TEXT, "a");
        send_item(ACT_END, 8'h00);
    endtask

    // Key with j, dropped characters and a duplicate, then key done twice
    // and a late key letter, which must all be ignored
    task automatic test_key_entry();
        logic [7:0] first;
        first = 8'($urandom_range(97, 122));
        send_item(ACT_KEY, "j");
        send_item(ACT_KEY, 8'h00);
        send_item(ACT_KEY, 8'hFF);
        send_item(ACT_KEY, " ");
        send_item(ACT_KEY, first);
        repeat (2) send_item(ACT_KEY, 8'($urandom_range(97, 122)));
        send_item(ACT_KEY, first);
        send_item(ACT_DONE, 8'h00);
        send_item(ACT_DONE, 8'hFF);
        send_item(ACT_KEY, "k");
    endtask

    // Pairs picked off the shadow square so every rule is hit
    task automatic test_special_pairs();
        send_item(ACT_END, "q");            // nothing held
        send_item(ACT_TEXT, "x");           // xx -> (x,x), one cell
        send_item(ACT_TEXT, "x");
        send_item(ACT_END, 8'h00);          // held x padded with z
        send_item(ACT_TEXT, "i");           // raw i/j differ, same cell
        send_item(ACT_TEXT, "j");
        send_item(ACT_TEXT, "z");           // zz -> (z,x), then (z,z)
        send_item(ACT_TEXT, "z");
        send_item(ACT_END, 8'h00);
        send_item(ACT_TEXT, char_of(sq_cell[0]));   // same row
        send_item(ACT_TEXT, char_of(sq_cell[4]));
        send_item(ACT_TEXT, char_of(sq_cell[5]));   // same column
        send_item(ACT_TEXT, char_of(sq_cell[20]));
        send_item(ACT_TEXT, char_of(sq_cell[1]));   // rectangle
        send_item(ACT_TEXT, char_of(sq_cell[18]));
    endtask

    // Mostly text with doubles and j, some dropped characters, ends of
    // message and ignored key items; now and then waits for all results
    task automatic test_random_text(input int n);
        int         useful;
        int         r;
        logic [7:0] ch;
        logic [7:0] prev;
        useful = 0;
        prev   = "a";
        while (useful < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    ch = prev;
                else if (r < 26)
                    ch = "j";
                else
                    ch = 8'($urandom_range(97, 122));
                prev = ch;
                send_item(ACT_TEXT, ch);
                useful++;
            end else if (r < 78) begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch >= CH_LOWER_A && ch < CH_LOWER_END);
                send_item(ACT_TEXT, ch);
            end else if (r < 90) begin
                send_item(ACT_END, 8'($urandom_range(0, 255)));
                useful++;
            end else if (r < 95) begin
                send_item(ACT_KEY, 8'($urandom_range(0, 255)));
            end else begin
                send_item(ACT_DONE, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 2)
                wait_results_drained();
        end
    endtask

    // Receiver holds off for a long stretch while text keeps coming, so
    // the block fills and stalls its input; then the sender waits for all
    // results before going on
    task automatic test_output_stall();
        steady          = 1'b1;
        out_hold_cycles = 300;
        repeat (40) send_item(ACT_TEXT, 8'($urandom_range(97, 122)));
        send_item(ACT_END, 8'h00);
        steady = 1'b0;
        wait_results_drained();
    endtask

    // Back-to-back stretch with no idling on either side
    task automatic test_steady_burst();
        steady = 1'b1;
        test_random_text(300);
        steady = 1'b0;
    endtask

    initial begin
        timeout_guard();
    end

    task automatic timeout_guard();
        #4_000_000;
        $display("Timeout with %0d cipher letters still expected", cipher_expected.size());
        $display("*** FAILED ***");
        $finish;
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_KEY;
        in_ch.letter = 8'h00;
        i_rst_n      = 1'b0;
        steady       = 1'b0;
        out_hold_cycles = 0;
        out_idle     = 0;
        errors       = 0;
        n_items      = 0;
        n_letters    = 0;
        n_row        = 0;
        n_col        = 0;
        n_rect       = 0;
        n_doubles    = 0;
        sq_fill      = 0;
        sq_ready     = 1'b0;
        held_letter  = 5'd0;
        held_valid   = 1'b0;
        for (int k = 0; k < ALPHA; k++) begin
            sq_pos[k]  = 5'd0;
            sq_used[k] = 1'b0;
        end
        for (int k = 0; k < CELLS; k++)
            sq_cell[k] = 5'd0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_text_before_key();
        test_key_entry();
        test_special_pairs();
        test_random_text(600);
        test_output_stall();
        test_steady_burst();
        test_random_text(750);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait_results_drained();
        // key done walk is the longest stretch with no result
        repeat (40) @(posedge i_clk);

        $display("Sent %0d items, checked %0d cipher letters", n_items, n_letters);
        $display("Digraphs: %0d row, %0d column, %0d rectangle, %0d doubled letters",
                 n_row, n_col, n_rect, n_doubles);
        if (errors == 0 && cipher_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/pfe_pkg.sv
design/pfe_if.sv
design/pfe_rule.sv
design/playfair_digraph_encryptor_top.sv
dv/tb_playfair_digraph_encryptor_top.sv
